@@ design/exlex_pkg.sv @@
package exlex_pkg;

	// One input beat: a code point or the end-of-stream marker
	typedef struct packed {
		logic [20:0] code;
		logic        is_end;
	} in_item_t;

	// One result beat
	typedef struct packed {
		logic [20:0] out_code;
		logic [3:0]  token_class;
		logic        first_char;
		logic        last_char;
		logic [1:0]  error_code;
		logic        stream_end;
	} out_item_t;

	// Up to two results produced by one scanned item
	typedef struct packed {
		logic [1:0] n;
		out_item_t  r0;
		out_item_t  r1;
	} res_push_t;

	// Token classes
	localparam logic [3:0] CLS_BRACKET = 4'd0;
	localparam logic [3:0] CLS_PERCENT = 4'd1;
	localparam logic [3:0] CLS_SEP     = 4'd2;
	localparam logic [3:0] CLS_DOTS    = 4'd3;
	localparam logic [3:0] CLS_STRING  = 4'd4;
	localparam logic [3:0] CLS_ATOM    = 4'd5;
	localparam logic [3:0] CLS_OPER    = 4'd6;
	localparam logic [3:0] CLS_SUB     = 4'd7;
	localparam logic [3:0] CLS_NUMBER  = 4'd8;

	// Error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_COMMENT = 2'd1;
	localparam logic [1:0] ERR_STRING  = 2'd2;
	localparam logic [1:0] ERR_INVALID = 2'd3;

	// Result queue depth
	localparam int RQ_DEPTH = 4;

endpackage

@@ design/expression_lexer.sv @@
// Streaming expression lexer. Each beat on the input carries one code point or an
// end-of-stream marker; the block skips whitespace and comments and returns every kept
// character as a result beat with its token class and first/last marks, one item late,
// plus error beats (invalid character, open comment or string at the end) and a closing
// stream-end beat. It scans one item per clock while the result queue has room: an item waits
// in the input register, is scanned there in a single pass and its zero, one or two results
// enter a four-entry result queue, from which they are read out (results of a character come
// out when the next item is scanned). The input stalls only while the result queue has fewer
// than two free entries, so one item per cycle is sustained as long as the output takes one
// beat per cycle and items produce at most one result on average. The configuration register
// is always ready.
module expression_lexer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  exlex_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output exlex_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data
);
	import exlex_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      nonascii_q;
	logic      room;
	logic      fire;
	res_push_t push;

	assign fire      = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;
	assign cfg_ready = 1'b1;

	// Input register: load a new beat whenever the held one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			nonascii_q <= 1'b1;
		else if (cfg_valid && cfg_ready)
			nonascii_q <= cfg_data;
	end

	exlex_step u_step (
		.clk                (clk),
		.arst_n             (arst_n),
		.fire               (fire),
		.item               (item_s1),
		.nonascii_is_letter (nonascii_q),
		.push               (push)
	);

	exlex_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ design/exlex_step.sv @@
module exlex_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  exlex_pkg::in_item_t item,
	input  logic                nonascii_is_letter,
	output exlex_pkg::res_push_t push
);
	import exlex_pkg::*;

	typedef enum logic [14:0] {
		M_IDLE  = 15'h0001,
		M_SLASH = 15'h0002,
		M_BLOCK = 15'h0004,
		M_LINE  = 15'h0008,
		M_ONE   = 15'h0010,
		M_DOT1  = 15'h0020,
		M_DOTS  = 15'h0040,
		M_STR   = 15'h0080,
		M_ATOM  = 15'h0100,
		M_OP    = 15'h0200,
		M_SUB   = 15'h0400,
		M_NINT  = 15'h0800,
		M_NFRAC = 15'h1000,
		M_NEXPS = 15'h2000,
		M_NEXPD = 15'h4000
	} lex_mode_t;

	localparam logic [20:0] CH_LF     = 21'h0A;
	localparam logic [20:0] CH_QUOTE  = 21'h22;
	localparam logic [20:0] CH_PCT    = 21'h25;
	localparam logic [20:0] CH_STAR   = 21'h2A;
	localparam logic [20:0] CH_PLUS   = 21'h2B;
	localparam logic [20:0] CH_MINUS  = 21'h2D;
	localparam logic [20:0] CH_DOT    = 21'h2E;
	localparam logic [20:0] CH_SLASH  = 21'h2F;
	localparam logic [20:0] CH_BSLASH = 21'h5C;
	localparam logic [20:0] CH_UNDER  = 21'h5F;
	localparam logic [20:0] CH_E_UP   = 21'h45;
	localparam logic [20:0] CH_E_LO   = 21'h65;

	lex_mode_t   mode_q, mode_d;
	logic        held_valid_q, held_valid_d;
	logic        esc_q, esc_d;
	logic        star_q, star_d;
	logic [20:0] held_char_q, held_char_d;
	logic [3:0]  held_class_q, held_class_d;
	logic        held_first_q, held_first_d;

	logic        emit_h, h_last, emit_s, do_cont, do_start;
	logic [3:0]  h_cls;
	out_item_t   res_h, res_s;
	logic [20:0] c;
	logic        c_digit, c_space, c_alpha, c_sym, c_bracket;

	// Character classes of the current code point
	always_comb begin
		c         = item.code;
		c_digit   = (c >= 21'h30) && (c <= 21'h39);
		c_space   = (c == 21'h20) || ((c >= 21'd9) && (c <= 21'd13));
		c_alpha   = ((c >= 21'h61) && (c <= 21'h7A)) || ((c >= 21'h41) && (c <= 21'h5A)) ||
		            (c == 21'h27) || ((c > 21'd127) && nonascii_is_letter);
		c_sym     = c inside {21'h7E, 21'h60, 21'h21, 21'h40, 21'h23, 21'h24, 21'h5E,
		                      21'h26, 21'h2A, 21'h2D, 21'h3D, 21'h2B, 21'h3A, 21'h3C,
		                      21'h3E, 21'h3F, 21'h2F, 21'h5C, 21'h7C};
		c_bracket = c inside {21'h28, 21'h29, 21'h7B, 21'h7D, 21'h5B, 21'h5D};
	end

	// Scan one item: decide what the held character does and what is held next
	always_comb begin
		mode_d       = mode_q;
		held_valid_d = held_valid_q;
		esc_d        = esc_q;
		star_d       = star_q;
		held_char_d  = held_char_q;
		held_class_d = held_class_q;
		held_first_d = held_first_q;
		emit_h       = 1'b0;
		h_last       = 1'b0;
		h_cls        = held_class_q;
		emit_s       = 1'b0;
		do_cont      = 1'b0;
		do_start     = 1'b0;
		res_s        = '0;

		if (item.is_end) begin
			// flush, then close the stream with the marker beat
			emit_h       = held_valid_q && (mode_q != M_STR);
			h_last       = 1'b1;
			emit_s       = 1'b1;
			res_s.stream_end = 1'b1;
			if (mode_q == M_BLOCK)
				res_s.error_code = ERR_COMMENT;
			else if (mode_q == M_STR)
				res_s.error_code = ERR_STRING;
			held_valid_d = 1'b0;
			mode_d       = M_IDLE;
			esc_d        = 1'b0;
			star_d       = 1'b0;
		end else begin
			case (mode_q)
				M_BLOCK: begin
					if (star_q && (c == CH_SLASH)) begin
						mode_d = M_IDLE;
						star_d = 1'b0;
					end else begin
						star_d = (c == CH_STAR);
					end
				end
				M_LINE: begin
					if (c == CH_LF)
						mode_d = M_IDLE;
				end
				M_STR: begin
					if (esc_q) begin
						esc_d   = 1'b0;
						do_cont = 1'b1;
					end else if (c == CH_BSLASH) begin
						esc_d   = 1'b1;
					end else begin
						if (c == CH_QUOTE)
							mode_d = M_ONE;
						do_cont = 1'b1;
					end
				end
				M_SLASH: begin
					if (c == CH_STAR) begin
						held_valid_d = 1'b0;
						mode_d       = M_BLOCK;
						star_d       = 1'b0;
					end else if (c == CH_SLASH) begin
						held_valid_d = 1'b0;
						mode_d       = M_LINE;
					end else if (c_sym) begin
						mode_d  = M_OP;
						do_cont = 1'b1;
					end else begin
						do_start = 1'b1;
					end
				end
				M_DOT1: begin
					if (c_digit) begin
						h_cls   = CLS_NUMBER;
						mode_d  = M_NINT;
						do_cont = 1'b1;
					end else if (c == CH_DOT) begin
						mode_d  = M_DOTS;
						do_cont = 1'b1;
					end else begin
						do_start = 1'b1;
					end
				end
				M_DOTS: begin
					do_cont  = (c == CH_DOT);
					do_start = !(c == CH_DOT);
				end
				M_ATOM: begin
					do_cont  = c_alpha || c_digit;
					do_start = !(c_alpha || c_digit);
				end
				M_OP: begin
					do_cont  = c_sym;
					do_start = !c_sym;
				end
				M_SUB: begin
					do_cont  = (c == CH_UNDER);
					do_start = !(c == CH_UNDER);
				end
				M_NINT: begin
					if (c_digit) begin
						do_cont = 1'b1;
					end else if (c == CH_DOT) begin
						mode_d  = M_NFRAC;
						do_cont = 1'b1;
					end else if ((c == CH_E_LO) || (c == CH_E_UP)) begin
						mode_d  = M_NEXPS;
						do_cont = 1'b1;
					end else begin
						do_start = 1'b1;
					end
				end
				M_NFRAC: begin
					if (c_digit) begin
						do_cont = 1'b1;
					end else if ((c == CH_E_LO) || (c == CH_E_UP)) begin
						mode_d  = M_NEXPS;
						do_cont = 1'b1;
					end else begin
						do_start = 1'b1;
					end
				end
				M_NEXPS: begin
					if (c_digit || (c == CH_PLUS) || (c == CH_MINUS)) begin
						mode_d  = M_NEXPD;
						do_cont = 1'b1;
					end else begin
						do_start = 1'b1;
					end
				end
				M_NEXPD: begin
					do_cont  = c_digit;
					do_start = !c_digit;
				end
				default: begin
					// idle, single-character tokens and meaningless codes
					do_start = 1'b1;
				end
			endcase

			// continue the token: emit the held character, hold this one
			if (do_cont) begin
				emit_h       = held_valid_q;
				h_last       = 1'b0;
				held_valid_d = 1'b1;
				held_char_d  = c;
				held_class_d = h_cls;
				held_first_d = 1'b0;
			end

			// end the token and scan this character from idle
			if (do_start) begin
				emit_h       = held_valid_q;
				h_last       = 1'b1;
				mode_d       = M_IDLE;
				held_valid_d = 1'b1;
				held_char_d  = c;
				held_first_d = 1'b1;
				if (c_space) begin
					held_valid_d = 1'b0;
				end else if (c == CH_SLASH) begin
					held_class_d = CLS_OPER;
					mode_d       = M_SLASH;
				end else if (c_bracket) begin
					held_class_d = CLS_BRACKET;
					mode_d       = M_ONE;
				end else if (c == CH_PCT) begin
					held_class_d = CLS_PERCENT;
					mode_d       = M_ONE;
				end else if ((c == 21'h2C) || (c == 21'h3B)) begin
					held_class_d = CLS_SEP;
					mode_d       = M_ONE;
				end else if (c == CH_DOT) begin
					held_class_d = CLS_DOTS;
					mode_d       = M_DOT1;
				end else if (c == CH_QUOTE) begin
					held_class_d = CLS_STRING;
					mode_d       = M_STR;
					esc_d        = 1'b0;
				end else if (c_alpha) begin
					held_class_d = CLS_ATOM;
					mode_d       = M_ATOM;
				end else if (c_sym) begin
					held_class_d = CLS_OPER;
					mode_d       = M_OP;
				end else if (c == CH_UNDER) begin
					held_class_d = CLS_SUB;
					mode_d       = M_SUB;
				end else if (c_digit) begin
					held_class_d = CLS_NUMBER;
					mode_d       = M_NINT;
				end else begin
					held_valid_d     = 1'b0;
					emit_s           = 1'b1;
					res_s.out_code   = c;
					res_s.error_code = ERR_INVALID;
				end
			end
		end
	end

	// Assemble the results in order
	always_comb begin
		res_h             = '0;
		res_h.out_code    = held_char_q;
		res_h.token_class = h_cls;
		res_h.first_char  = held_first_q;
		res_h.last_char   = h_last;
		push              = '0;
		if (fire) begin
			if (emit_h) begin
				push.r0 = res_h;
				push.r1 = res_s;
				push.n  = emit_s ? 2'd2 : 2'd1;
			end else begin
				push.r0 = res_s;
				push.n  = emit_s ? 2'd1 : 2'd0;
			end
		end
	end

	// Advance control state on each scanned item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			held_valid_q <= 1'b0;
			esc_q        <= 1'b0;
			star_q       <= 1'b0;
		end else if (fire) begin
			mode_q       <= mode_d;
			held_valid_q <= held_valid_d;
			esc_q        <= esc_d;
			star_q       <= star_d;
		end
	end

	// Held character payload
	always_ff @(posedge clk) begin
		if (fire) begin
			held_char_q  <= held_char_d;
			held_class_q <= held_class_d;
			held_first_q <= held_first_d;
		end
	end

endmodule

@@ design/exlex_rq.sv @@
module exlex_rq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  exlex_pkg::res_push_t push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_stall,
	output exlex_pkg::out_item_t out_data
);
	import exlex_pkg::*;

	localparam int PTR_W = $clog2(RQ_DEPTH);

	out_item_t        mem [RQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             pop;
	logic [PTR_W-1:0] wr_ptr_p1;

	assign wr_ptr_p1 = wr_ptr_q + PTR_W'(1);
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign room      = (count_q <= (PTR_W+1)'(RQ_DEPTH - 2));
	assign out_data  = mem[rd_ptr_q];

	// Write up to two result beats
	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem[wr_ptr_q] <= push.r0;
		if (push.n == 2'd2)
			mem[wr_ptr_p1] <= push.r1;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + (PTR_W+1)'(push.n) - (PTR_W+1)'(pop);
		end
	end

endmodule

@@ tb/sv/tb_expression_lexer.sv @@
`timescale 1ns / 1ps

module tb_expression_lexer;
	import exlex_pkg::*;

	// Token class carried by error and stream-end beats
	localparam logic [3:0]  CLS_NONE    = 4'd0;
	localparam logic [20:0] CH_BACKTICK = 21'h60;
	localparam logic [20:0] CODE_TOP    = 21'h10FFFF;
	localparam int          IDLE_LIMIT  = 2000;
	localparam int          DRAIN_GAP   = 8;
	localparam int          HALF_PHASE  = 155;

	typedef enum logic [3:0] {
		SC_IDLE, SC_SLASH, SC_BLOCK, SC_LINE, SC_ONE, SC_DOT1, SC_DOTS, SC_STR,
		SC_ATOM, SC_OPER, SC_SUB, SC_NINT, SC_NFRAC, SC_NEXPS, SC_NEXPD
	} scan_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;

	// Scanner copy: mode, held character and register
	scan_mode_t  sc_mode = SC_IDLE;
	logic [20:0] hold_code = '0;
	logic [3:0]  hold_cls = '0;
	logic        hold_vld = 1'b0;
	logic        hold_first = 1'b0;
	logic        esc_pend = 1'b0;
	logic        star_prev = 1'b0;
	logic        letter_hi = 1'b1;

	in_item_t  chars_q[$];
	out_item_t lexed_q[$];
	int        n_fail = 0;
	int        in_idle_pct = 0;
	int        out_stall_pct = 0;
	int        idle_cnt = 0;

	expression_lexer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Character classes
	function automatic bit is_digit(logic [20:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_space(logic [20:0] c);
		return c == " " || (c >= 21'd9 && c <= 21'd13);
	endfunction

	function automatic bit is_letter(logic [20:0] c);
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "'")
			return 1'b1;
		return c > 21'd127 && letter_hi;
	endfunction

	function automatic bit is_sym(logic [20:0] c);
		return c inside {"~", CH_BACKTICK, "!", "@", "#", "$", "^", "&", "*", "-", "=",
			"+", ":", "<", ">", "?", "/", "\\", "|"};
	endfunction

	// Queue one predicted result beat
	function automatic void emit(logic [20:0] code, logic [3:0] cls, logic first,
		logic last, logic [1:0] err, logic done);
		out_item_t r;
		r.out_code    = code;
		r.token_class = cls;
		r.first_char  = first;
		r.last_char   = last;
		r.error_code  = err;
		r.stream_end  = done;
		lexed_q.insert(lexed_q.size(), r);
	endfunction

	function automatic void emit_held(logic last);
		if (hold_vld) begin
			emit(hold_code, hold_cls, hold_first, last, ERR_NONE, 1'b0);
			hold_vld = 1'b0;
		end
	endfunction

	function automatic void keep(logic [20:0] c, logic [3:0] cls, logic first);
		hold_code  = c;
		hold_cls   = cls;
		hold_first = first;
		hold_vld   = 1'b1;
	endfunction

	// Scan a character from idle
	function automatic void begin_token(logic [20:0] c);
		sc_mode = SC_IDLE;
		if (is_space(c)) begin
		end else if (c == "/") begin
			keep(c, CLS_OPER, 1'b1);
			sc_mode = SC_SLASH;
		end else if (c inside {"(", ")", "{", "}", "[", "]"}) begin
			keep(c, CLS_BRACKET, 1'b1);
			sc_mode = SC_ONE;
		end else if (c == "%") begin
			keep(c, CLS_PERCENT, 1'b1);
			sc_mode = SC_ONE;
		end else if (c == "," || c == ";") begin
			keep(c, CLS_SEP, 1'b1);
			sc_mode = SC_ONE;
		end else if (c == ".") begin
			keep(c, CLS_DOTS, 1'b1);
			sc_mode = SC_DOT1;
		end else if (c == "\"") begin
			keep(c, CLS_STRING, 1'b1);
			sc_mode = SC_STR;
			esc_pend = 1'b0;
		end else if (is_letter(c)) begin
			keep(c, CLS_ATOM, 1'b1);
			sc_mode = SC_ATOM;
		end else if (is_sym(c)) begin
			keep(c, CLS_OPER, 1'b1);
			sc_mode = SC_OPER;
		end else if (c == "_") begin
			keep(c, CLS_SUB, 1'b1);
			sc_mode = SC_SUB;
		end else if (is_digit(c)) begin
			keep(c, CLS_NUMBER, 1'b1);
			sc_mode = SC_NINT;
		end else begin
			emit(c, CLS_NONE, 1'b0, 1'b0, ERR_INVALID, 1'b0);
		end
	endfunction

	// Advance the scanner by one accepted item and predict its results
	function automatic void scan_item(in_item_t it);
		logic [20:0] c;
		logic [1:0]  err;
		logic [3:0]  cls;
		bit          cont;
		c = it.code;
		cont = 1'b0;
		if (it.is_end) begin
			err = ERR_NONE;
			if (sc_mode == SC_BLOCK) begin
				err = ERR_COMMENT;
			end else if (sc_mode == SC_STR) begin
				err = ERR_STRING;
				hold_vld = 1'b0;
			end
			emit_held(1'b1);
			emit('0, CLS_NONE, 1'b0, 1'b0, err, 1'b1);
			sc_mode = SC_IDLE;
			esc_pend = 1'b0;
			star_prev = 1'b0;
			return;
		end
		case (sc_mode)
			SC_BLOCK: begin
				if (star_prev && c == "/") begin
					sc_mode = SC_IDLE;
					star_prev = 1'b0;
				end else begin
					star_prev = (c == "*");
				end
				return;
			end
			SC_LINE: begin
				if (c == "\n")
					sc_mode = SC_IDLE;
				return;
			end
			SC_STR: begin
				if (esc_pend) begin
					esc_pend = 1'b0;
				end else if (c == "\\") begin
					esc_pend = 1'b1;
					return;
				end else if (c == "\"") begin
					sc_mode = SC_ONE;
				end
				emit_held(1'b0);
				keep(c, CLS_STRING, 1'b0);
				return;
			end
			SC_SLASH: begin
				if (c == "*") begin
					hold_vld = 1'b0;
					sc_mode = SC_BLOCK;
					star_prev = 1'b0;
					return;
				end
				if (c == "/") begin
					hold_vld = 1'b0;
					sc_mode = SC_LINE;
					return;
				end
				sc_mode = SC_OPER;
				cont = is_sym(c);
			end
			SC_DOT1: begin
				if (is_digit(c)) begin
					hold_cls = CLS_NUMBER;
					sc_mode = SC_NINT;
					cont = 1'b1;
				end else if (c == ".") begin
					sc_mode = SC_DOTS;
					cont = 1'b1;
				end
			end
			SC_DOTS: cont = (c == ".");
			SC_ATOM: cont = is_letter(c) || is_digit(c);
			SC_OPER: cont = is_sym(c);
			SC_SUB:  cont = (c == "_");
			SC_NINT: begin
				if (is_digit(c)) begin
					cont = 1'b1;
				end else if (c == ".") begin
					sc_mode = SC_NFRAC;
					cont = 1'b1;
				end else if (c == "e" || c == "E") begin
					sc_mode = SC_NEXPS;
					cont = 1'b1;
				end
			end
			SC_NFRAC: begin
				if (is_digit(c)) begin
					cont = 1'b1;
				end else if (c == "e" || c == "E") begin
					sc_mode = SC_NEXPS;
					cont = 1'b1;
				end
			end
			SC_NEXPS: begin
				if (is_digit(c) || c == "+" || c == "-") begin
					sc_mode = SC_NEXPD;
					cont = 1'b1;
				end
			end
			SC_NEXPD: cont = is_digit(c);
			default: ;
		endcase
		if (cont) begin
			cls = hold_cls;
			emit_held(1'b0);
			keep(c, cls, 1'b0);
		end else begin
			emit_held(1'b1);
			begin_token(c);
		end
	endfunction

	// Stimulus helpers
	function automatic void push_code(logic [20:0] c);
		chars_q.insert(chars_q.size(), '{code: c, is_end: 1'b0});
	endfunction

	function automatic void push_end();
		chars_q.insert(chars_q.size(),
			'{code: 21'($urandom_range(0, CODE_TOP)), is_end: 1'b1});
	endfunction

	function automatic void push_text(string s);
		foreach (s[i])
			push_code(21'(s[i]));
	endfunction

	function automatic logic [20:0] any_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 21'($urandom_range(32, 126));
		if (r < 75)
			return 21'($urandom_range(0, 31));
		if (r < 85)
			return 21'($urandom_range(127, 255));
		return 21'($urandom_range(0, CODE_TOP));
	endfunction

	function automatic logic [20:0] letter_char();
		int unsigned r;
		r = $urandom_range(0, 64);
		if (r < 26)
			return 21'("A" + r);
		if (r < 52)
			return 21'("a" + r - 26);
		if (r < 55)
			return 21'("'");
		return 21'($urandom_range(128, CODE_TOP));
	endfunction

	function automatic logic [20:0] digit_char();
		return 21'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [20:0] sym_char();
		string ops;
		ops = "~!@#$^&*-=+:<>?/\\|";
		if ($urandom_range(0, 18) == 0)
			return CH_BACKTICK;
		return 21'(ops[$urandom_range(0, ops.len() - 1)]);
	endfunction

	function automatic logic [20:0] space_char();
		if ($urandom_range(0, 5) == 0)
			return 21'(" ");
		return 21'($urandom_range(9, 13));
	endfunction

	// Append one mostly well-formed token, a comment, some noise or an end-of-stream marker
	function automatic void gen_token();
		string brackets;
		int unsigned r;
		brackets = "(){}[]";
		case ($urandom_range(0, 19))
			0: push_code(21'(brackets[$urandom_range(0, 5)]));
			1: push_code("%");
			2: push_code($urandom_range(0, 1) ? 21'(",") : 21'(";"));
			3: repeat ($urandom_range(1, 4)) push_code(".");
			4: begin
				push_code("\"");
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 4) == 0)
						push_code("\\");
					push_code(any_char());
				end
				if ($urandom_range(0, 9) != 0)
					push_code("\"");
			end
			5, 6: begin
				push_code(letter_char());
				repeat ($urandom_range(0, 5))
					push_code($urandom_range(0, 2) == 0 ? digit_char() : letter_char());
			end
			7: repeat ($urandom_range(1, 4)) push_code(sym_char());
			8: repeat ($urandom_range(1, 3)) push_code("_");
			9, 10: begin
				if ($urandom_range(0, 3) == 0)
					push_code(".");
				repeat ($urandom_range(1, 4)) push_code(digit_char());
				if ($urandom_range(0, 1) == 0) begin
					push_code(".");
					repeat ($urandom_range(0, 3)) push_code(digit_char());
				end
				if ($urandom_range(0, 2) == 0) begin
					push_code($urandom_range(0, 1) ? 21'("e") : 21'("E"));
					if ($urandom_range(0, 1) == 0)
						push_code($urandom_range(0, 1) ? 21'("+") : 21'("-"));
					repeat ($urandom_range(0, 3)) push_code(digit_char());
				end
			end
			11: begin
				push_text("/*");
				repeat ($urandom_range(0, 8)) begin
					r = $urandom_range(0, 5);
					push_code(r == 0 ? 21'("*") : r == 1 ? 21'("/") : any_char());
				end
				if ($urandom_range(0, 6) != 0)
					push_text("*/");
			end
			12: begin
				push_text("//");
				repeat ($urandom_range(0, 6)) push_code(21'($urandom_range(32, 126)));
				if ($urandom_range(0, 9) != 0)
					push_code("\n");
			end
			13: repeat ($urandom_range(1, 3)) push_code(space_char());
			14: begin
				r = $urandom_range(0, 2);
				push_code(r == 0 ? 21'($urandom_range(0, 8)) :
					r == 1 ? 21'($urandom_range(14, 31)) : 21'd127);
			end
			15: push_code(21'($urandom_range(0, CODE_TOP)));
			16: push_code(21'($urandom_range(128, CODE_TOP)));
			17: begin
				if ($urandom_range(0, 1) == 0)
					push_end();
				else
					push_code(any_char());
			end
			default: push_code(any_char());
		endcase
		if ($urandom_range(0, 1) == 0)
			push_code(space_char());
	endfunction

	function automatic void make_stream(int n);
		int target;
		target = chars_q.size() + n;
		while (chars_q.size() < target)
			gen_token();
	endfunction

	// Field compare
	function automatic void cmp_field(string name, logic [20:0] want, logic [20:0] got);
		if (want !== got) begin
			n_fail++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	function automatic void check_beat(out_item_t got);
		out_item_t want;
		if (lexed_q.size() == 0) begin
			n_fail++;
			$error("unexpected result beat: out_code %0h", got.out_code);
			return;
		end
		want = lexed_q.pop_front();
		cmp_field("out_code", want.out_code, got.out_code);
		cmp_field("token_class", 21'(want.token_class), 21'(got.token_class));
		cmp_field("first_char", 21'(want.first_char), 21'(got.first_char));
		cmp_field("last_char", 21'(want.last_char), 21'(got.last_char));
		cmp_field("error_code", 21'(want.error_code), 21'(got.error_code));
		cmp_field("stream_end", 21'(want.stream_end), 21'(got.stream_end));
	endfunction

	// Driver: predict on each accepted beat, then present the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				scan_item(in_data);
			if (!in_valid || !in_stall) begin
				if (chars_q.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= chars_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result beat, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_beat(out_data);
			out_stall <= ($urandom_range(0, 99) < out_stall_pct);
		end
	end

	// Watchdog: count cycles with no beat moving on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
				idle_cnt <= 0;
			end else if (idle_cnt >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cnt <= idle_cnt + 1;
			end
		end
	end

	task automatic write_cfg(logic v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		letter_hi = v;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Hold until every queued item is sent and every predicted beat has come back
	task automatic wait_drained();
		do @(negedge clk); while (chars_q.size() > 0 || in_valid || lexed_q.size() > 0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				2: begin in_idle_pct = 75; out_stall_pct = 0;  end
				3: begin in_idle_pct = 0;  out_stall_pct = 75; end
				4: begin in_idle_pct = 6;  out_stall_pct = 6;  end
				default: begin in_idle_pct = 0; out_stall_pct = 0; end
			endcase
			write_cfg(ph == 0 || ph == 2 || ph == 4);
			if (ph == 0) begin
				// opener star must not close, leading dot number with signed exponent
				push_text("/*/*/");
				push_text(".5e-3");
				push_text("(%,..+_");
				push_code('0);
				push_code(CODE_TOP);
				// line comment closed by end, open string, open comment
				push_text("//");
				push_end();
				push_text("\"a\\\"");
				push_end();
				push_text("/*");
			end else begin
				make_stream(HALF_PHASE);
				wait_drained();
				make_stream(HALF_PHASE);
			end
			push_end();
			wait_drained();
			repeat (DRAIN_GAP) @(posedge clk);
		end
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ expression_lexer.f @@
design/exlex_pkg.sv
design/exlex_step.sv
design/exlex_rq.sv
design/expression_lexer.sv
tb/sv/tb_expression_lexer.sv
